// File: rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Types and constants shared by the session sequence correlator.
// ----------------------------------------------------------------------------
`default_nettype none
package ssc_pkg;

  localparam int KEY_W    = 16;
  localparam int CAP_W    = 8;
  localparam int TIME_W   = 32;
  localparam int RISK_W   = 8;
  localparam int ACT_W    = 2;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int RULE_REGS = 4;

  localparam int RULE_LEN_LSB = 48;
  localparam int RULE_LEN_W   = 3;
  localparam int RULE_ACT_LSB = 51;

  localparam logic [CFG_IDX_W-1:0] REG_RULE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RULE_WORD0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RULE_WORD3 = 3'd4;

  localparam logic [ACT_W-1:0] ACT_ALLOW = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WARN  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BLOCK = 2'd2;

  localparam logic [RISK_W-1:0] RISK_MAX         = 8'd255;
  localparam logic [RISK_W-1:0] RISK_BLOCK_LIMIT = 8'd200;
  localparam logic [RISK_W-1:0] RISK_BLOCK_ADD   = 8'd50;
  localparam logic [RISK_W-1:0] RISK_WARN_LIMIT  = 8'd240;
  localparam logic [RISK_W-1:0] RISK_WARN_ADD    = 8'd10;

  typedef struct packed {
    logic [KEY_W-1:0]  session_key_in;
    logic [CAP_W-1:0]  capability;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [ACT_W-1:0]  verdict;
    logic [RISK_W-1:0] risk_level;
    logic              fresh_session;
  } rsp_t;

  typedef struct packed {
    logic              append;
    logic              apply;
    logic              fresh;
    logic [KEY_W-1:0]  key;
    logic [CAP_W-1:0]  cap;
    logic [TIME_W-1:0] now;
  } cell_cmd_t;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [ACT_W-1:0]  verdict;
    logic [RISK_W-1:0] risk_next;
  } cell_stat_t;

endpackage
`default_nettype wire

// File: rtl/ssc_stream_if.sv
// ----------------------------------------------------------------------------
// ssc_stream_if
// Valid/ready stream channel carrying one request or response.
// ----------------------------------------------------------------------------
`default_nettype none
interface ssc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/ssc_cell.sv
// ----------------------------------------------------------------------------
// ssc_cell
// One session slot: key, last-seen time, history shift line, fill and risk.
// Passes the running oldest-slot record on to its neighbor every cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ssc_cell #(
  parameter int HISTORY_DEPTH = 8,
  parameter int MAX_SEQ_LEN   = 6,
  parameter int RULES         = 4,
  parameter int SW            = 3,
  parameter int INDEX         = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ssc_pkg::cell_cmd_t            cmd,
  input  wire logic                          sel,
  input  wire logic [ssc_pkg::CFG_W-1:0]     rule_word [RULES],
  input  wire logic [RULES-1:0]              rule_en,
  input  wire logic                          min_any_in,
  input  wire logic [ssc_pkg::TIME_W-1:0]    min_time_in,
  input  wire logic [SW-1:0]                 min_idx_in,
  output logic                               min_any_out,
  output logic [ssc_pkg::TIME_W-1:0]         min_time_out,
  output logic [SW-1:0]                      min_idx_out,
  output ssc_pkg::cell_stat_t                stat
);

  localparam int TAPS = (HISTORY_DEPTH < MAX_SEQ_LEN) ? HISTORY_DEPTH : MAX_SEQ_LEN;
  localparam int FW   = $clog2(HISTORY_DEPTH + 1);

  logic                          valid;
  logic [ssc_pkg::KEY_W-1:0]     key;
  logic [ssc_pkg::TIME_W-1:0]    last_seen;
  logic [ssc_pkg::CAP_W-1:0]     hist [TAPS];
  logic [FW-1:0]                 fill;
  logic [ssc_pkg::RISK_W-1:0]    risk;
  logic [ssc_pkg::ACT_W-1:0]     worst;
  logic [ssc_pkg::RISK_W-1:0]    risk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      fill  <= '0;
      risk  <= '0;
    end else if (sel && cmd.append) begin
      valid <= 1'b1;
      if (cmd.fresh) begin
        fill <= FW'(1);
        risk <= '0;
      end else if (fill < FW'(HISTORY_DEPTH)) begin
        fill <= fill + FW'(1);
      end
    end else if (sel && cmd.apply) begin
      risk <= risk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.append) begin
      key       <= cmd.key;
      last_seen <= cmd.now;
      hist[0]   <= cmd.cap;
      for (int t = 1; t < TAPS; t++) hist[t] <= hist[t-1];
    end
  end

  // oldest-slot chain, ties keep the lower slot
  always_ff @(posedge clk) begin
    if (rst) begin
      min_any_out <= 1'b0;
    end else begin
      min_any_out <= 1'b1;
    end
    if (!min_any_in || last_seen < min_time_in) begin
      min_time_out <= last_seen;
      min_idx_out  <= SW'(INDEX);
    end else begin
      min_time_out <= min_time_in;
      min_idx_out  <= min_idx_in;
    end
  end

  always_comb begin
    logic [ssc_pkg::RULE_LEN_W-1:0] len;
    logic [ssc_pkg::ACT_W-1:0]      act;
    logic                           seq_ok;
    logic                           ok;
    worst = ssc_pkg::ACT_ALLOW;
    for (int r = 0; r < RULES; r++) begin
      len    = rule_word[r][ssc_pkg::RULE_LEN_LSB +: ssc_pkg::RULE_LEN_W];
      act    = rule_word[r][ssc_pkg::RULE_ACT_LSB +: ssc_pkg::ACT_W];
      seq_ok = (len == '0);
      for (int l = 1; l <= TAPS; l++) begin
        ok = 1'b1;
        for (int i = 0; i < l; i++) begin
          if (hist[l-1-i] != rule_word[r][8*i +: 8]) ok = 1'b0;
        end
        if (int'(len) == l) seq_ok = ok;
      end
      if (rule_en[r] && int'(len) <= MAX_SEQ_LEN && int'(len) <= int'(fill) && seq_ok &&
          act > worst) begin
        worst = act;
      end
    end
  end

  always_comb begin
    unique case (worst)
      ssc_pkg::ACT_BLOCK:
        risk_next = (risk > ssc_pkg::RISK_BLOCK_LIMIT) ? ssc_pkg::RISK_MAX
                                                       : risk + ssc_pkg::RISK_BLOCK_ADD;
      ssc_pkg::ACT_WARN:
        risk_next = (risk > ssc_pkg::RISK_WARN_LIMIT) ? ssc_pkg::RISK_MAX
                                                      : risk + ssc_pkg::RISK_WARN_ADD;
      default: risk_next = risk;
    endcase
  end

  assign stat.valid     = valid;
  assign stat.hit       = valid && (key == cmd.key);
  assign stat.verdict   = worst;
  assign stat.risk_next = risk_next;

endmodule
`default_nettype wire

// File: rtl/session_sequence_correlator_core.sv
// ----------------------------------------------------------------------------
// session_sequence_correlator_core
// Session table as a row of cells; per-session history and rule matching.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  req     | in  | valid/ready     | session_key_in, capability, now_ms
//  rsp     | out | valid/ready     | verdict, risk_level, fresh_session
//  cfg     | in  | cfg_we          | cfg_index, cfg_data
//
//  A request is taken in IDLE and then passes through SCAN, while the
//  oldest-slot record ripples down the cell row, then APPEND, which picks
//  the slot and appends, then APPLY, which matches and scores.
//  A new request is taken the cycle after the previous response leaves the
//  output reg, so only one request is in flight and a response stall holds
//  off the next request.
//  Synchronous reset clears slot valid, fill and risk; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module session_sequence_correlator_core #(
  parameter int SESSIONS      = 8,
  parameter int HISTORY_DEPTH = 8,
  parameter int RULES         = 4,
  parameter int MAX_SEQ_LEN   = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  ssc_stream_if.sink                         req,
  ssc_stream_if.source                       rsp,
  input  wire logic                          cfg_we,
  input  wire logic [ssc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ssc_pkg::CFG_W-1:0]     cfg_data
);

  localparam int SW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int CW = $clog2(SESSIONS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_APPEND = 2'd2;
  localparam logic [1:0] S_APPLY  = 2'd3;

  logic [1:0]                   state;
  logic [CW-1:0]                cnt;
  ssc_pkg::req_t                req_q;
  logic [SESSIONS-1:0]          sel_oh;
  logic [SESSIONS-1:0]          sel_next;
  logic                         fresh_q;
  logic                         fresh_next;
  logic                         out_valid;
  ssc_pkg::rsp_t                out_q;
  logic [2:0]                   rule_count;
  logic [ssc_pkg::CFG_W-1:0]    rule_word [ssc_pkg::RULE_REGS];
  logic [ssc_pkg::CFG_W-1:0]    cell_rules [RULES];
  logic [RULES-1:0]             rule_en;
  ssc_pkg::cell_cmd_t           cmd;
  ssc_pkg::cell_stat_t          stat [SESSIONS];
  logic [SESSIONS-1:0]          hit_vec;
  logic [SESSIONS-1:0]          free_vec;
  logic [SESSIONS-1:0]          cell_sel;
  logic                         chain_any  [SESSIONS+1];
  logic [ssc_pkg::TIME_W-1:0]   chain_time [SESSIONS+1];
  logic [SW-1:0]                chain_idx  [SESSIONS+1];
  ssc_pkg::rsp_t                pick;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0;
      for (int r = 0; r < ssc_pkg::RULE_REGS; r++) rule_word[r] <= '0;
    end else if (cfg_we) begin
      priority if (cfg_index == ssc_pkg::REG_RULE_COUNT) begin
        rule_count <= cfg_data[2:0];
      end else if (cfg_index >= ssc_pkg::REG_RULE_WORD0 &&
                   cfg_index <= ssc_pkg::REG_RULE_WORD3) begin
        rule_word[2'(cfg_index - ssc_pkg::REG_RULE_WORD0)] <= cfg_data;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < RULES; r++) begin
      cell_rules[r] = rule_word[r];
      rule_en[r]    = (r < int'(rule_count));
    end
  end

  assign chain_any[0]  = 1'b0;
  assign chain_time[0] = '0;
  assign chain_idx[0]  = '0;

  assign cmd.append = (state == S_APPEND);
  assign cmd.apply  = (state == S_APPLY);
  assign cmd.fresh  = fresh_next;
  assign cmd.key    = req_q.session_key_in;
  assign cmd.cap    = req_q.capability;
  assign cmd.now    = req_q.now_ms;

  assign cell_sel = (state == S_APPEND) ? sel_next : sel_oh;

  for (genvar g = 0; g < SESSIONS; g++) begin : g_cell
    ssc_cell #(
      .HISTORY_DEPTH(HISTORY_DEPTH),
      .MAX_SEQ_LEN  (MAX_SEQ_LEN),
      .RULES        (RULES),
      .SW           (SW),
      .INDEX        (g)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .sel         (cell_sel[g]),
      .rule_word   (cell_rules),
      .rule_en     (rule_en),
      .min_any_in  (chain_any[g]),
      .min_time_in (chain_time[g]),
      .min_idx_in  (chain_idx[g]),
      .min_any_out (chain_any[g+1]),
      .min_time_out(chain_time[g+1]),
      .min_idx_out (chain_idx[g+1]),
      .stat        (stat[g])
    );
    assign hit_vec[g]  = stat[g].hit;
    assign free_vec[g] = !stat[g].valid;
  end

  // hit, else lowest free slot, else oldest
  always_comb begin
    fresh_next = !(|hit_vec);
    if (|hit_vec) begin
      sel_next = hit_vec & (~hit_vec + SESSIONS'(1));
    end else if (|free_vec) begin
      sel_next = free_vec & (~free_vec + SESSIONS'(1));
    end else begin
      sel_next = SESSIONS'(1) << chain_idx[SESSIONS];
    end
  end

  always_comb begin
    pick = '0;
    for (int s = 0; s < SESSIONS; s++) begin
      if (sel_oh[s]) begin
        pick.verdict    = pick.verdict | stat[s].verdict;
        pick.risk_level = pick.risk_level | stat[s].risk_next;
      end
    end
    pick.fresh_session = fresh_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            state <= S_SCAN;
            cnt   <= CW'(SESSIONS - 1);
          end
        end
        S_SCAN: begin
          if (cnt == '0) state <= S_APPEND;
          else cnt <= cnt - CW'(1);
        end
        S_APPEND: state <= S_APPLY;
        S_APPLY: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) req_q <= req.data;
    if (state == S_APPEND) begin
      sel_oh  <= sel_next;
      fresh_q <= fresh_next;
    end
    if (state == S_APPLY) out_q <= pick;
  end

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_q;

  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    state == S_APPEND |-> $onehot0(hit_vec)) else $error("duplicate session key");
  a_sel_onehot: assert property (@(posedge clk) disable iff (rst)
    state == S_APPLY |-> $onehot(sel_oh)) else $error("slot select not one-hot");
  a_append_apply: assert property (@(posedge clk) disable iff (rst)
    state == S_APPEND |=> state == S_APPLY) else $error("append not followed by apply");
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !req.ready) else $error("request taken while response pending");

endmodule
`default_nettype wire

// File: dv/session_sequence_correlator_core_tb.sv
// ----------------------------------------------------------------------------
// session_sequence_correlator_core_tb
// Drives requests with random gaps and response stalls, keeps a private copy
// of the session table, history rings and rules to predict each verdict,
// risk level and fresh flag, and compares every response in order.
// ----------------------------------------------------------------------------
`default_nettype none
module session_sequence_correlator_core_tb;

  localparam int SESS   = 8;
  localparam int HDEPTH = 8;
  localparam int NRULES = 4;
  localparam int MAXLEN = 6;
  localparam int DRAIN  = 30;
  localparam int WDOG   = 3000;
  localparam logic [ssc_pkg::ACT_W-1:0] ACT_OTHER = 2'd3;
  localparam logic [ssc_pkg::CFG_IDX_W-1:0] REG_UNUSED = ssc_pkg::REG_RULE_WORD3 + 3'd1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [ssc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ssc_pkg::CFG_W-1:0] cfg_data = '0;

  ssc_stream_if #(.payload_t(ssc_pkg::req_t)) req_if ();
  ssc_stream_if #(.payload_t(ssc_pkg::rsp_t)) rsp_if ();

  session_sequence_correlator_core u_top (
    .clk(clk), .rst(rst), .req(req_if.sink), .rsp(rsp_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [2:0] rule_cnt;
  logic [ssc_pkg::CFG_W-1:0] rule_words [NRULES];
  bit sess_valid [SESS];
  logic [ssc_pkg::KEY_W-1:0] sess_key [SESS];
  logic [ssc_pkg::TIME_W-1:0] sess_seen [SESS];
  logic [ssc_pkg::CAP_W-1:0] hist [SESS][HDEPTH];
  int hist_head [SESS];
  int hist_fill [SESS];
  logic [ssc_pkg::RISK_W-1:0] sess_risk [SESS];

  ssc_pkg::rsp_t verdict_q [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit burst = 1'b0;
  int rsp_stall = 0;
  logic [ssc_pkg::CAP_W-1:0] alpha [4];
  logic [ssc_pkg::KEY_W-1:0] keys [12];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic ssc_pkg::rsp_t predict_verdict(ssc_pkg::req_t r);
    int slot, oldest, n, len, pos;
    logic [ssc_pkg::ACT_W-1:0] worst, act;
    logic [ssc_pkg::CFG_W-1:0] w;
    bit fresh, hit;
    ssc_pkg::rsp_t o;
    slot = -1;
    fresh = 1'b0;
    worst = ssc_pkg::ACT_ALLOW;
    for (int i = 0; i < SESS; i++) begin
      if (sess_valid[i] && sess_key[i] == r.session_key_in) begin
        slot = i;
        break;
      end
    end
    if (slot < 0) begin
      oldest = 0;
      for (int i = 0; i < SESS; i++) begin
        if (!sess_valid[i]) begin
          slot = i;
          break;
        end
        if (sess_seen[i] < sess_seen[oldest]) oldest = i;
      end
      if (slot < 0) slot = oldest;
      sess_valid[slot] = 1'b1;
      sess_key[slot] = r.session_key_in;
      hist_head[slot] = 0;
      hist_fill[slot] = 0;
      sess_risk[slot] = '0;
      for (int j = 0; j < HDEPTH; j++) hist[slot][j] = '0;
      fresh = 1'b1;
    end
    hist[slot][hist_head[slot]] = r.capability;
    hist_head[slot] = (hist_head[slot] + 1) % HDEPTH;
    if (hist_fill[slot] < HDEPTH) hist_fill[slot]++;
    sess_seen[slot] = r.now_ms;
    n = (rule_cnt > NRULES) ? NRULES : rule_cnt;
    for (int i = 0; i < n; i++) begin
      w = rule_words[i];
      len = w[ssc_pkg::RULE_LEN_LSB +: ssc_pkg::RULE_LEN_W];
      hit = (len <= MAXLEN) && (len <= hist_fill[slot]);
      for (int j = 0; j < len && hit; j++) begin
        pos = (hist_head[slot] + HDEPTH - len + j) % HDEPTH;
        if (hist[slot][pos] != w[8*j +: 8]) hit = 1'b0;
      end
      act = w[ssc_pkg::RULE_ACT_LSB +: ssc_pkg::ACT_W];
      if (hit && act > worst) worst = act;
    end
    if (worst == ssc_pkg::ACT_BLOCK)
      sess_risk[slot] = (sess_risk[slot] > ssc_pkg::RISK_BLOCK_LIMIT) ? ssc_pkg::RISK_MAX
                        : sess_risk[slot] + ssc_pkg::RISK_BLOCK_ADD;
    else if (worst == ssc_pkg::ACT_WARN)
      sess_risk[slot] = (sess_risk[slot] > ssc_pkg::RISK_WARN_LIMIT) ? ssc_pkg::RISK_MAX
                        : sess_risk[slot] + ssc_pkg::RISK_WARN_ADD;
    o.verdict = worst;
    o.risk_level = sess_risk[slot];
    o.fresh_session = fresh;
    return o;
  endfunction

  function automatic logic [ssc_pkg::CFG_W-1:0] make_rule(int len,
                                                          logic [ssc_pkg::ACT_W-1:0] act,
                                                          logic [47:0] seq);
    logic [ssc_pkg::CFG_W-1:0] w;
    w = '0;
    w[47:0] = seq;
    w[ssc_pkg::RULE_LEN_LSB +: ssc_pkg::RULE_LEN_W] = 3'(len);
    w[ssc_pkg::RULE_ACT_LSB +: ssc_pkg::ACT_W] = act;
    return w;
  endfunction

  // called at a posedge; leaves valid high after the request is taken
  task automatic send_req(logic [ssc_pkg::KEY_W-1:0] key, logic [ssc_pkg::CAP_W-1:0] cap,
                          logic [ssc_pkg::TIME_W-1:0] now);
    int gap;
    ssc_pkg::req_t r;
    gap = pick_gap();
    r.session_key_in = key;
    r.capability = cap;
    r.now_ms = now;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= r;
    @(negedge clk);
    while (!req_if.ready) @(negedge clk);
    @(posedge clk);
    verdict_q.push_back(predict_verdict(r));
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_rules(logic [2:0] cnt, logic [ssc_pkg::CFG_W-1:0] w0,
                             logic [ssc_pkg::CFG_W-1:0] w1,
                             logic [ssc_pkg::CFG_W-1:0] w2, logic [ssc_pkg::CFG_W-1:0] w3);
    logic [ssc_pkg::CFG_W-1:0] ws [NRULES];
    ws = '{w0, w1, w2, w3};
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= ssc_pkg::REG_RULE_COUNT;
    cfg_data <= {{(ssc_pkg::CFG_W-3){1'b1}}, cnt};
    @(posedge clk);
    rule_cnt = cnt;
    for (int i = 0; i < NRULES; i++) begin
      cfg_index <= ssc_pkg::REG_RULE_WORD0 + 3'(i);
      cfg_data <= ws[i];
      @(posedge clk);
      rule_words[i] = ws[i];
    end
    cfg_index <= REG_UNUSED + 3'($urandom_range(0, 2));
    cfg_data <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ssc_pkg::CFG_W-1:0] random_rule();
    int len;
    logic [47:0] seq;
    len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7);
    for (int i = 0; i < 6; i++) seq[8*i +: 8] = alpha[$urandom_range(0, 3)];
    return make_rule(len, 2'($urandom_range(0, 3)), seq);
  endfunction

  task automatic test_directed();
    burst = 1'b0;
    send_req(16'h0000, 8'h00, 32'h0);
    send_req(16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    // len 0 warns always, len 7 never matches, 3-byte block, 1-byte other
    write_rules(3'd7, make_rule(0, ssc_pkg::ACT_WARN, '0),
                make_rule(7, ssc_pkg::ACT_BLOCK, '1),
                make_rule(3, ssc_pkg::ACT_BLOCK, 48'h0000_00CC_BBAA),
                make_rule(1, ACT_OTHER, 48'h0000_0000_00FF));
    send_req(16'hFFFF, 8'hAA, 32'h10);
    send_req(16'hFFFF, 8'hBB, 32'h11);
    send_req(16'hFFFF, 8'hCC, 32'h12);
    send_req(16'hFFFF, 8'hFF, 32'h13);
    for (int i = 0; i < 6; i++) send_req(16'hFFFF, 8'hAA + 8'(17 * (i % 3)), 32'h14 + i);
    // fill the table with equal times, then force an eviction on the tie
    for (int i = 1; i < 9; i++) send_req(16'h0100 + 16'(i), 8'h5A, 32'h20);
    send_req(16'h8000, 8'h00, 32'h0);
  endtask

  task automatic test_saturation();
    write_rules(3'd1, make_rule(0, ssc_pkg::ACT_BLOCK, '0), '0, '0, '0);
    for (int i = 0; i < 7; i++) send_req(16'h00AB, 8'h11, 32'h100 + i);
    write_rules(3'd4, make_rule(0, ssc_pkg::ACT_WARN, '0), '0, '0, '0);
    for (int i = 0; i < 4; i++) send_req(16'h00AB, 8'h11, 32'h200 + i);
    for (int i = 0; i < 27; i++) send_req(16'h00CD, 8'h22, 32'h300 + i);
  endtask

  task automatic test_random_phase(int items, int mode);
    logic [ssc_pkg::TIME_W-1:0] now;
    logic [ssc_pkg::KEY_W-1:0] key;
    logic [ssc_pkg::CAP_W-1:0] cap;
    int r;
    for (int i = 0; i < 4; i++) alpha[i] = 8'($urandom);
    for (int i = 0; i < 12; i++) keys[i] = 16'($urandom);
    if (mode == 0) write_rules(3'd0, '0, '0, '0, '0);
    else if (mode == 1) write_rules(3'd7, '1, '1, '1, '1);
    else write_rules(3'($urandom_range(0, 7)), random_rule(), random_rule(),
                     random_rule(), random_rule());
    now = (mode == 3) ? 32'hFFFF_FF00 : $urandom;
    for (int n = 0; n < items; n++) begin
      if (n % 60 == 0) burst = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      now = (r < 85) ? now + $urandom_range(0, 50) : $urandom;
      key = (r < 90) ? keys[$urandom_range(0, (mode == 4) ? 11 : 8)] : 16'($urandom);
      cap = (r % 10 < 8) ? alpha[$urandom_range(0, 3)] : 8'($urandom);
      send_req(key, cap, now);
    end
    burst = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rsp_stall > 0) begin
      rsp_if.ready <= 1'b0;
      rsp_stall <= rsp_stall - 1;
    end else begin
      rsp_if.ready <= 1'b1;
      rsp_stall <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
  end

  always @(negedge clk) begin
    ssc_pkg::rsp_t want;
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", rsp_if.data);
      end else begin
        want = verdict_q.pop_front();
        if (rsp_if.data.verdict !== want.verdict ||
            rsp_if.data.risk_level !== want.risk_level ||
            rsp_if.data.fresh_session !== want.fresh_session) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response mismatch: expected %p got %p", want, rsp_if.data);
        end
      end
    end
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    rule_cnt = '0;
    for (int i = 0; i < NRULES; i++) rule_words[i] = '0;
    for (int i = 0; i < SESS; i++) begin
      sess_valid[i] = 1'b0;
      sess_key[i] = '0;
      sess_seen[i] = '0;
      hist_head[i] = 0;
      hist_fill[i] = 0;
      sess_risk[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_random_phase(150, 0);
    test_random_phase(150, 1);
    test_random_phase(300, 2);
    test_random_phase(300, 3);
    test_random_phase(300, 4);
    test_random_phase(300, 2);
    wait_drained();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
rtl/ssc_pkg.sv
rtl/ssc_stream_if.sv
rtl/ssc_cell.sv
rtl/session_sequence_correlator_core.sv
dv/session_sequence_correlator_core_tb.sv
